/* hw/rtl/depth_pixel_to_world_point_unit_macros.svh */
// ----------------------------------------------------------------------------
// depth pixel to world point unit: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef DEPTH_PIXEL_TO_WORLD_POINT_UNIT_MACROS_SVH
`define DEPTH_PIXEL_TO_WORLD_POINT_UNIT_MACROS_SVH

// same-cycle implication
`define DP2W_ASSERT_IMPLIES(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dp2w same-cycle check failed");

// next-cycle implication
`define DP2W_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dp2w next-cycle check failed");

`endif

/* hw/rtl/dp2w_pkg.sv */
// ----------------------------------------------------------------------------
// dp2w_pkg
// Types and constants of the depth pixel to world point unit.
// ----------------------------------------------------------------------------
package dp2w_pkg;

	// configuration register indexes
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_METERS_PER_DEPTH_UNIT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_X              = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_CENTER_Y              = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_X           = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_INV_FOCAL_Y           = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_POSE_QUATERNION       = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_POSE_TRANSLATION      = 3'd6;

	// pipeline geometry
	localparam int NUM_STAGES = 11;

	// datapath widths
	localparam int DEPTH_W = 16;
	localparam int COLOR_W = 8;
	localparam int Z_W     = 32;   // unsigned Q.16 meters
	localparam int SLOPE_W = 32;   // signed Q.16
	localparam int PNT_W   = 41;   // signed Q.16 camera coordinate
	localparam int PNT_LO_W = 20;  // low split of a camera coordinate
	localparam int QUAT_W  = 16;   // signed Q1.14
	localparam int QPROD_W = 32;
	localparam int RENT_W  = 36;   // matrix entry in Q.28
	localparam int ROT_W   = 20;   // matrix entry in Q.14
	localparam int TRANS_W = 21;   // signed Q10.10
	localparam int ACC_W   = 64;   // Q.30 accumulator
	localparam int COORD_W = 32;   // signed Q15.16 result

	typedef struct packed {
		logic [31:0] meters_per_depth_unit;
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [23:0] inv_focal_x;
		logic [23:0] inv_focal_y;
		logic [63:0] pose_quaternion;
		logic [62:0] pose_translation;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		meters_per_depth_unit: 32'd4294967,
		center_x:              16'd5208,
		center_y:              16'd4056,
		inv_focal_x:           24'd32388,
		inv_focal_y:           24'd32326,
		pose_quaternion:       64'h4000_0000_0000_0000,
		pose_translation:      63'd0
	};

	typedef struct packed {
		logic [COLOR_W-1:0] blue;
		logic [COLOR_W-1:0] green;
		logic [COLOR_W-1:0] red;
	} color_t;

	typedef logic [2:0][PNT_W-1:0]   point_t;   // x, y, z from index 0
	typedef logic [8:0][ROT_W-1:0]   rot_mat_t; // row-major, entry i*3+j
	typedef logic [2:0][COORD_W-1:0] world_t;

endpackage

/* hw/rtl/dp2w_rotation.sv */
// ----------------------------------------------------------------------------
// dp2w_rotation
// Rotation matrix from the pose quaternion, two register levels deep.
// ----------------------------------------------------------------------------
module dp2w_rotation
	import dp2w_pkg::*;
(
	input  logic        clk,
	input  logic [63:0] pose_quaternion,
	output rot_mat_t    rot_q
);

	localparam logic signed [RENT_W-1:0] ONE  = RENT_W'(64'd1 << 28);
	localparam logic signed [RENT_W-1:0] HALF = RENT_W'(64'd1 << 13);

	logic signed [QUAT_W-1:0] qw, qx, qy, qz;
	logic signed [QPROD_W-1:0] xx_q, yy_q, zz_q, xy_q, xz_q, yz_q, wx_q, wy_q, wz_q;
	logic signed [RENT_W-1:0] ent [9];

	assign qw = $signed(pose_quaternion[63:48]);
	assign qx = $signed(pose_quaternion[47:32]);
	assign qy = $signed(pose_quaternion[31:16]);
	assign qz = $signed(pose_quaternion[15:0]);

	always_ff @(posedge clk) begin
		xx_q <= qx * qx;
		yy_q <= qy * qy;
		zz_q <= qz * qz;
		xy_q <= qx * qy;
		xz_q <= qx * qz;
		yz_q <= qy * qz;
		wx_q <= qw * qx;
		wy_q <= qw * qy;
		wz_q <= qw * qz;
	end

	always_comb begin
		logic signed [RENT_W-1:0] exx, eyy, ezz, exy, exz, eyz, ewx, ewy, ewz;
		exx = xx_q;
		eyy = yy_q;
		ezz = zz_q;
		exy = xy_q;
		exz = xz_q;
		eyz = yz_q;
		ewx = wx_q;
		ewy = wy_q;
		ewz = wz_q;
		ent[0] = ONE - ((eyy + ezz) <<< 1);
		ent[1] = (exy - ewz) <<< 1;
		ent[2] = (exz + ewy) <<< 1;
		ent[3] = (exy + ewz) <<< 1;
		ent[4] = ONE - ((exx + ezz) <<< 1);
		ent[5] = (eyz - ewx) <<< 1;
		ent[6] = (exz - ewy) <<< 1;
		ent[7] = (eyz + ewx) <<< 1;
		ent[8] = ONE - ((exx + eyy) <<< 1);
	end

	// round Q.28 to Q.14; the result always fits ROT_W bits
	always_ff @(posedge clk) begin
		for (int k = 0; k < 9; k++) begin
			rot_q[k] <= ROT_W'((ent[k] + HALF) >>> 14);
		end
	end

endmodule

/* hw/rtl/dp2w_camera.sv */
// ----------------------------------------------------------------------------
// dp2w_camera
// Stages 1 to 6: depth scaling and pinhole back-projection to camera space.
// ----------------------------------------------------------------------------
module dp2w_camera
	import dp2w_pkg::*;
#(
	parameter int PIXEL_INDEX_BITS = 11
) (
	input  logic                        clk,
	input  logic [NUM_STAGES-1:0]       ld,
	input  cfg_t                        cfg,
	input  logic [PIXEL_INDEX_BITS-1:0] pixel_row,
	input  logic [PIXEL_INDEX_BITS-1:0] pixel_col,
	input  logic [DEPTH_W-1:0]          raw_depth,
	input  color_t                      color,
	output point_t                      pnt_s6,
	output color_t                      color_s6
);

	// signed offset from principal point in Q.4
	localparam int DW    = (PIXEL_INDEX_BITS + 5 > 17) ? PIXEL_INDEX_BITS + 5 : 17;
	localparam int SXP_W = DW + 25;
	localparam int CP_W  = SLOPE_W + Z_W + 1;

	localparam logic signed [SXP_W-1:0] SX_HALF = SXP_W'(64'd1 << 11);
	localparam logic signed [SXP_W-1:0] SL_MAX  = SXP_W'(64'd1 << 30);
	localparam logic signed [SXP_W-1:0] SL_MIN  = -SL_MAX;
	localparam logic signed [CP_W-1:0]  CP_HALF = CP_W'(64'd1 << 15);
	localparam logic signed [CP_W-1:0]  CP_MAX  = CP_W'((64'd1 << 40) - 64'd1);
	localparam logic signed [CP_W-1:0]  CP_MIN  = -CP_W'(64'd1 << 40);

	logic [PIXEL_INDEX_BITS-1:0] row_s1, col_s1;
	logic [DEPTH_W-1:0]          depth_s1, depth_s2;
	color_t                      color_s1, color_s2, color_s3, color_s4, color_s5;
	logic signed [DW-1:0]        dx_s2, dy_s2;
	logic [47:0]                 zprod_s3;
	logic signed [SXP_W-1:0]     sxprod_s3, syprod_s3;
	logic [Z_W-1:0]              zq_s4, zq_s5;
	logic signed [SLOPE_W-1:0]   slope_x_s4, slope_y_s4;
	logic signed [CP_W-1:0]      cxprod_s5, cyprod_s5;

	logic [47:0]                 zsum;
	logic signed [SXP_W-1:0]     sx_rnd, sy_rnd;
	logic signed [SLOPE_W-1:0]   slope_x, slope_y;
	logic signed [CP_W-1:0]      cx_rnd, cy_rnd;
	logic signed [PNT_W-1:0]     cam_x, cam_y;

	// stage 1: capture the pixel
	always_ff @(posedge clk) begin
		if (ld[0]) begin
			row_s1   <= pixel_row;
			col_s1   <= pixel_col;
			depth_s1 <= raw_depth;
			color_s1 <= color;
		end
	end

	// stage 2: offsets from the principal point
	always_ff @(posedge clk) begin
		if (ld[1]) begin
			dx_s2    <= $signed({{(DW-PIXEL_INDEX_BITS-4){1'b0}}, col_s1, 4'b0})
				- $signed({{(DW-16){1'b0}}, cfg.center_x});
			dy_s2    <= $signed({{(DW-PIXEL_INDEX_BITS-4){1'b0}}, row_s1, 4'b0})
				- $signed({{(DW-16){1'b0}}, cfg.center_y});
			depth_s2 <= depth_s1;
			color_s2 <= color_s1;
		end
	end

	// stage 3: depth scale and slope products
	always_ff @(posedge clk) begin
		if (ld[2]) begin
			zprod_s3  <= 48'(depth_s2) * 48'(cfg.meters_per_depth_unit);
			sxprod_s3 <= dx_s2 * $signed({1'b0, cfg.inv_focal_x});
			syprod_s3 <= dy_s2 * $signed({1'b0, cfg.inv_focal_y});
			color_s3  <= color_s2;
		end
	end

	// stage 4: round z to Q.16, round and clamp slopes
	always_comb begin
		zsum   = zprod_s3 + 48'h8000;
		sx_rnd = (sxprod_s3 + SX_HALF) >>> 12;
		sy_rnd = (syprod_s3 + SX_HALF) >>> 12;
		if (sx_rnd > SL_MAX) begin
			slope_x = SLOPE_W'(SL_MAX);
		end else if (sx_rnd < SL_MIN) begin
			slope_x = SLOPE_W'(SL_MIN);
		end else begin
			slope_x = SLOPE_W'(sx_rnd);
		end
		if (sy_rnd > SL_MAX) begin
			slope_y = SLOPE_W'(SL_MAX);
		end else if (sy_rnd < SL_MIN) begin
			slope_y = SLOPE_W'(SL_MIN);
		end else begin
			slope_y = SLOPE_W'(sy_rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[3]) begin
			zq_s4      <= zsum[47:16];
			slope_x_s4 <= slope_x;
			slope_y_s4 <= slope_y;
			color_s4   <= color_s3;
		end
	end

	// stage 5: camera coordinate products
	always_ff @(posedge clk) begin
		if (ld[4]) begin
			cxprod_s5 <= slope_x_s4 * $signed({1'b0, zq_s4});
			cyprod_s5 <= slope_y_s4 * $signed({1'b0, zq_s4});
			zq_s5     <= zq_s4;
			color_s5  <= color_s4;
		end
	end

	// stage 6: round and clamp the camera point
	always_comb begin
		cx_rnd = (cxprod_s5 + CP_HALF) >>> 16;
		cy_rnd = (cyprod_s5 + CP_HALF) >>> 16;
		if (cx_rnd > CP_MAX) begin
			cam_x = PNT_W'(CP_MAX);
		end else if (cx_rnd < CP_MIN) begin
			cam_x = PNT_W'(CP_MIN);
		end else begin
			cam_x = PNT_W'(cx_rnd);
		end
		if (cy_rnd > CP_MAX) begin
			cam_y = PNT_W'(CP_MAX);
		end else if (cy_rnd < CP_MIN) begin
			cam_y = PNT_W'(CP_MIN);
		end else begin
			cam_y = PNT_W'(cy_rnd);
		end
	end

	always_ff @(posedge clk) begin
		if (ld[5]) begin
			pnt_s6[0] <= cam_x;
			pnt_s6[1] <= cam_y;
			pnt_s6[2] <= {{(PNT_W-Z_W){1'b0}}, zq_s5};
			color_s6  <= color_s5;
		end
	end

endmodule

/* hw/rtl/dp2w_transform.sv */
// ----------------------------------------------------------------------------
// dp2w_transform
// Stages 7 to 11: rotation, translation, rounding and saturation.
// ----------------------------------------------------------------------------
module dp2w_transform
	import dp2w_pkg::*;
(
	input  logic                  clk,
	input  logic [NUM_STAGES-1:0] ld,
	input  point_t                pnt_s6,
	input  color_t                color_s6,
	input  rot_mat_t              rot_q,
	input  logic [62:0]           pose_translation,
	output world_t                world_s11,
	output color_t                color_s11
);

	localparam int PH_W = PNT_W - PNT_LO_W;
	localparam int PP_W = ROT_W + PH_W;

	localparam logic signed [ACC_W-1:0] W_HALF = ACC_W'(64'd1 << 13);
	localparam logic signed [ACC_W-1:0] W_MAX  = ACC_W'(64'h7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] W_MIN  = -ACC_W'(64'h8000_0000);

	logic signed [PP_W-1:0]  prod_lo_s7 [3][3];
	logic signed [PP_W-1:0]  prod_hi_s7 [3][3];
	logic signed [ACC_W-1:0] term_s8    [3][3];
	logic signed [ACC_W-1:0] part_a_s9  [3];
	logic signed [ACC_W-1:0] part_b_s9  [3];
	logic signed [ACC_W-1:0] acc_s10    [3];
	color_t                  color_s7, color_s8, color_s9, color_s10;

	logic signed [ACC_W-1:0] term      [3][3];
	logic signed [ACC_W-1:0] trans_q30 [3];
	logic signed [ACC_W-1:0] w_rnd     [3];
	logic [COORD_W-1:0]      w_sat     [3];

	// stage 7: entry times point, point split into high and low halves
	always_ff @(posedge clk) begin
		if (ld[6]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_lo_s7[i][j] <= $signed(rot_q[i*3+j])
						* $signed({1'b0, pnt_s6[j][PNT_LO_W-1:0]});
					prod_hi_s7[i][j] <= $signed(rot_q[i*3+j])
						* $signed(pnt_s6[j][PNT_W-1:PNT_LO_W]);
				end
			end
			color_s7 <= color_s6;
		end
	end

	// stage 8: recombine the halves
	always_comb begin
		logic signed [ACC_W-1:0] hi, lo;
		hi = '0;
		lo = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				hi = prod_hi_s7[i][j];
				lo = prod_lo_s7[i][j];
				term[i][j] = (hi <<< PNT_LO_W) + lo;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[7]) begin
			term_s8  <= term;
			color_s8 <= color_s7;
		end
	end

	// stage 9: translation joins the first column
	always_comb begin
		logic signed [TRANS_W-1:0] t;
		t = '0;
		for (int i = 0; i < 3; i++) begin
			t = $signed(pose_translation[62-21*i -: TRANS_W]);
			trans_q30[i] = ACC_W'(t) <<< 20;
		end
	end

	always_ff @(posedge clk) begin
		if (ld[8]) begin
			for (int i = 0; i < 3; i++) begin
				part_a_s9[i] <= trans_q30[i] + term_s8[i][0];
				part_b_s9[i] <= term_s8[i][1] + term_s8[i][2];
			end
			color_s9 <= color_s8;
		end
	end

	// stage 10
	always_ff @(posedge clk) begin
		if (ld[9]) begin
			for (int i = 0; i < 3; i++) begin
				acc_s10[i] <= part_a_s9[i] + part_b_s9[i];
			end
			color_s10 <= color_s9;
		end
	end

	// stage 11: round Q.30 to Q.16 and saturate
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w_rnd[i] = (acc_s10[i] + W_HALF) >>> 14;
			if (w_rnd[i] > W_MAX) begin
				w_sat[i] = COORD_W'(W_MAX);
			end else if (w_rnd[i] < W_MIN) begin
				w_sat[i] = COORD_W'(W_MIN);
			end else begin
				w_sat[i] = COORD_W'(w_rnd[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld[10]) begin
			for (int i = 0; i < 3; i++) begin
				world_s11[i] <= w_sat[i];
			end
			color_s11 <= color_s10;
		end
	end

endmodule

/* hw/rtl/depth_pixel_to_world_point_unit.sv */
// ----------------------------------------------------------------------------
// depth_pixel_to_world_point_unit
// Back-projects depth pixels through a pinhole model and a pose into world
// points in signed Q15.16 meters, with the pixel color passed along.
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one pixel per transaction (row, column, raw depth, color).
//   a pixel with zero depth is taken and dropped; every other pixel yields one
//   m_axis transaction (world x, y, z and the color) in arrival order.
//   the cfg port writes the calibration and pose registers; write them only
//   while no pixel is in flight.
// timing:
//   eleven register stages; a pixel taken on s_axis moves through stages 1
//   to 11 and is offered on m_axis from the last stage.
//   one pixel per cycle sustained while m_axis does not stall, set by the stage pipeline.
//   after a pose write the rotation matrix settles through its product and
//   rounding registers, before any later pixel reaches the rotation stage.
// reset:
//   arst_n clears all stage valid bits and loads the default calibration.
// stall:
//   when m_axis_tready is low the last stage holds; earlier stages keep
//   filling empty slots, so s_axis_tready drops only when every stage is full.
// ----------------------------------------------------------------------------
`include "depth_pixel_to_world_point_unit_macros.svh"

module depth_pixel_to_world_point_unit
	import dp2w_pkg::*;
#(
	parameter int PIXEL_INDEX_BITS = 11
) (
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,

	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// pixel_row, pixel_col, raw_depth, red, green, blue, zero fill
	input  logic [((2*PIXEL_INDEX_BITS+40+7)/8)*8-1:0] s_axis_tdata,

	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// world_x, world_y, world_z, out_red, out_green, out_blue
	output logic [119:0]           m_axis_tdata
);

	localparam int PB = PIXEL_INDEX_BITS;

	cfg_t                  cfg_q;
	logic [NUM_STAGES-1:0] stage_valid_q;
	logic [NUM_STAGES-1:0] stage_ready;

	logic [PB-1:0]         in_row, in_col;
	logic [DEPTH_W-1:0]    in_depth;
	color_t                in_color;

	point_t                pnt_s6;
	color_t                color_s6, color_s11;
	rot_mat_t              rot_q;
	world_t                world_s11;

	assign in_row         = s_axis_tdata[PB-1:0];
	assign in_col         = s_axis_tdata[2*PB-1:PB];
	assign in_depth       = s_axis_tdata[2*PB+15:2*PB];
	assign in_color.red   = s_axis_tdata[2*PB+23:2*PB+16];
	assign in_color.green = s_axis_tdata[2*PB+31:2*PB+24];
	assign in_color.blue  = s_axis_tdata[2*PB+39:2*PB+32];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_METERS_PER_DEPTH_UNIT: cfg_q.meters_per_depth_unit <= cfg_data[31:0];
				REG_CENTER_X:              cfg_q.center_x              <= cfg_data[15:0];
				REG_CENTER_Y:              cfg_q.center_y              <= cfg_data[15:0];
				REG_INV_FOCAL_X:           cfg_q.inv_focal_x           <= cfg_data[23:0];
				REG_INV_FOCAL_Y:           cfg_q.inv_focal_y           <= cfg_data[23:0];
				REG_POSE_QUATERNION:       cfg_q.pose_quaternion       <= cfg_data;
				REG_POSE_TRANSLATION:      cfg_q.pose_translation      <= cfg_data[62:0];
				default: begin
				end
			endcase
		end
	end

	// a stage loads when it is empty or its content moves on
	always_comb begin
		stage_ready[NUM_STAGES-1] = !stage_valid_q[NUM_STAGES-1] || m_axis_tready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			stage_ready[k] = !stage_valid_q[k] || stage_ready[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			// zero depth is accepted but never enters the pipe
			if (stage_ready[0]) begin
				stage_valid_q[0] <= s_axis_tvalid && (in_depth != '0);
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (stage_ready[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	assign s_axis_tready = stage_ready[0];
	assign m_axis_tvalid = stage_valid_q[NUM_STAGES-1];
	assign m_axis_tdata  = {color_s11.blue, color_s11.green, color_s11.red,
		world_s11[2], world_s11[1], world_s11[0]};

	dp2w_rotation u_rotation (
		.clk             (clk),
		.pose_quaternion (cfg_q.pose_quaternion),
		.rot_q           (rot_q)
	);

	dp2w_camera #(
		.PIXEL_INDEX_BITS (PIXEL_INDEX_BITS)
	) u_camera (
		.clk       (clk),
		.ld        (stage_ready),
		.cfg       (cfg_q),
		.pixel_row (in_row),
		.pixel_col (in_col),
		.raw_depth (in_depth),
		.color     (in_color),
		.pnt_s6    (pnt_s6),
		.color_s6  (color_s6)
	);

	dp2w_transform u_transform (
		.clk              (clk),
		.ld               (stage_ready),
		.pnt_s6           (pnt_s6),
		.color_s6         (color_s6),
		.rot_q            (rot_q),
		.pose_translation (cfg_q.pose_translation),
		.world_s11        (world_s11),
		.color_s11        (color_s11)
	);

	`DP2W_ASSERT_NEXT(a_zero_depth_dropped, s_axis_tvalid && s_axis_tready && (in_depth == 16'd0), !stage_valid_q[0])
	`DP2W_ASSERT_NEXT(a_depth_enters, s_axis_tvalid && s_axis_tready && (in_depth != 16'd0), stage_valid_q[0])
	`DP2W_ASSERT_IMPLIES(a_blocked_only_when_full, !s_axis_tready, &stage_valid_q)
	`DP2W_ASSERT_NEXT(a_stalled_stage_keeps, stage_valid_q[5] && !stage_ready[6], stage_valid_q[5] && $stable(pnt_s6))

endmodule
